// ----- design/lsl_pkg.sv -----
// Shared constants for the LRU slot lookup block.
`default_nettype none
package lsl_pkg;
  localparam int unsigned KeyInW   = 32;
  localparam int unsigned StampW   = 32;
  localparam int unsigned SlotOutW = 2;

  typedef enum logic [0:0] {
    ModeLookup = 1'b0,
    ModeFlush  = 1'b1
  } mode_e;
endpackage
`default_nettype wire

// ----- design/lsl_select.sv -----
// Parallel key match, free-slot search and least-recently-used victim search.
`default_nettype none
module lsl_select #(
  parameter int unsigned SLOTS    = 3,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned IDX_W    = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0]          used_i,
  input  logic [KEY_BITS-1:0]       key_tab_i   [SLOTS],
  input  logic [lsl_pkg::StampW-1:0] stamp_tab_i [SLOTS],
  input  logic [KEY_BITS-1:0]       key_i,
  output logic                      hit_o,
  output logic [IDX_W-1:0]          hit_idx_o,
  output logic [IDX_W-1:0]          victim_idx_o,
  output logic                      evict_o
);
  import lsl_pkg::*;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] lru_idx;
  logic [StampW-1:0] lru_stamp;

  always_comb begin
    hit_o      = 1'b0;
    hit_idx_o  = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_i[i] && (key_tab_i[i] == key_i)) begin
        hit_o     = 1'b1;
        hit_idx_o = IDX_W'(i);
      end
      if (!used_i[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    lru_idx   = '0;
    lru_stamp = stamp_tab_i[0];
    for (int i = 1; i < SLOTS; i++) begin
      if (stamp_tab_i[i] < lru_stamp) begin
        lru_idx   = IDX_W'(i);
        lru_stamp = stamp_tab_i[i];
      end
    end
  end

  assign victim_idx_o = free_found ? free_idx : lru_idx;
  assign evict_o      = !free_found;
endmodule
`default_nettype wire

// ----- design/lru_slot_lookup.sv -----
// Top level of the fully associative LRU slot lookup table.
// A lookup transfer is captured in an input register; when the result register can
// advance, the slot table is searched and updated and the result register is loaded,
// so one transfer can be taken every cycle while out_ready_i does not hold the output.
// The rate is set by the combinational parallel key compare and stamp minimum
// search over all SLOTS entries. Key 0 (after masking to KEY_BITS) gets no slot and
// leaves the table and the tick untouched; a flush transfer clears all slots and
// the tick. Both produce a result with every field zero.
`default_nettype none
module lru_slot_lookup #(
  parameter int unsigned SLOTS    = 3,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [lsl_pkg::KeyInW-1:0]      lookup_key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            slot_given_o,
  output logic [lsl_pkg::SlotOutW-1:0]    slot_index_o,
  output logic                            was_hit_o,
  output logic                            evicted_used_o
);
  import lsl_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);

  logic                in_valid_q;
  logic                mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_d;
  logic [KEY_BITS+KeyInW-1:0] key_ext;

  logic [SLOTS-1:0]    used_q;
  logic [StampW-1:0]   stamp_q [SLOTS];
  logic [KEY_BITS-1:0] key_tab_q [SLOTS];
  logic [StampW-1:0]   tick_q;
  logic [StampW-1:0]   tick_inc;

  logic                res_valid_q;
  logic                given_q;
  logic [SlotOutW-1:0] index_q;
  logic                hit_q;
  logic                evict_q;

  logic                hit;
  logic [IdxW-1:0]     hit_idx;
  logic [IdxW-1:0]     victim_idx;
  logic                evict;
  logic [IdxW-1:0]     sel_idx;
  logic [IdxW+SlotOutW-1:0] sel_ext;

  logic advance;
  logic work;
  logic do_flush;
  logic do_lookup;

  assign key_ext = {{KEY_BITS{1'b0}}, lookup_key_i};
  assign key_d   = key_ext[KEY_BITS-1:0];

  assign advance    = !res_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign work       = in_valid_q && advance;
  assign do_flush   = work && (mode_e'(mode_q) == ModeFlush);
  assign do_lookup  = work && (mode_e'(mode_q) == ModeLookup) && (key_q != '0);
  assign tick_inc   = tick_q + StampW'(1);

  lsl_select #(
    .SLOTS   (SLOTS),
    .KEY_BITS(KEY_BITS),
    .IDX_W   (IdxW)
  ) u_select (
    .used_i      (used_q),
    .key_tab_i   (key_tab_q),
    .stamp_tab_i (stamp_q),
    .key_i       (key_q),
    .hit_o       (hit),
    .hit_idx_o   (hit_idx),
    .victim_idx_o(victim_idx),
    .evict_o     (evict)
  );

  assign sel_idx = hit ? hit_idx : victim_idx;
  assign sel_ext = {{SlotOutW{1'b0}}, sel_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q <= mode_i;
      key_q  <= key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      tick_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (do_flush) begin
      used_q <= '0;
      tick_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (do_lookup) begin
      tick_q           <= tick_inc;
      stamp_q[sel_idx] <= tick_inc;
      used_q[sel_idx]  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_lookup && !hit) begin
      key_tab_q[victim_idx] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      given_q <= do_lookup;
      index_q <= do_lookup ? sel_ext[SlotOutW-1:0] : '0;
      hit_q   <= do_lookup && hit;
      evict_q <= do_lookup && !hit && evict;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign slot_given_o   = given_q;
  assign slot_index_o   = index_q;
  assign was_hit_o      = hit_q;
  assign evicted_used_o = evict_q;
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the LRU slot lookup table with random idling and backpressure.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsl_pkg::*;

  localparam int unsigned NumSlots   = 3;
  localparam int unsigned NumRandom  = 550;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned PoolSize   = 5;

  typedef struct packed {
    mode_e             mode;
    logic [KeyInW-1:0] key;
  } lookup_req_t;

  typedef struct packed {
    logic                given;
    logic [SlotOutW-1:0] index;
    logic                hit;
    logic                evicted;
  } slot_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  mode_e             in_mode  = ModeLookup;
  logic [KeyInW-1:0] in_key   = '0;
  logic              out_ready = 1'b0;

  logic                in_ready_o;
  logic                out_valid_o;
  logic                slot_given_o;
  logic [SlotOutW-1:0] slot_index_o;
  logic                was_hit_o;
  logic                evicted_used_o;

  lookup_req_t  lookup_queue[$];
  slot_result_t expected_slots[$];
  slot_result_t want;
  lookup_req_t  next_req;

  logic              tbl_used[NumSlots];
  logic [StampW-1:0] tbl_stamp[NumSlots];
  logic [KeyInW-1:0] tbl_key[NumSlots];
  logic [StampW-1:0] model_tick;

  int unsigned       sent_count = 0;
  int unsigned       rcvd_count = 0;
  int unsigned       hold_left  = 0;
  logic              held_once  = 1'b0;
  int unsigned       stall_cycles = 0;
  logic              timed_out  = 1'b0;
  int unsigned       error_count = 0;
  logic [KeyInW-1:0] key_pool[PoolSize];

  lru_slot_lookup #(
    .SLOTS   (NumSlots),
    .KEY_BITS(KeyInW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .mode_i        (in_mode),
    .lookup_key_i  (in_key),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .slot_given_o  (slot_given_o),
    .slot_index_o  (slot_index_o),
    .was_hit_o     (was_hit_o),
    .evicted_used_o(evicted_used_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void clear_table();
    for (int i = 0; i < NumSlots; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_stamp[i] = '0;
      tbl_key[i]   = '0;
    end
    model_tick = '0;
  endfunction

  function automatic slot_result_t lru_lookup(mode_e mode, logic [KeyInW-1:0] key);
    slot_result_t res;
    int hit_at;
    int victim;
    res    = '0;
    hit_at = -1;
    victim = -1;
    if (mode == ModeFlush) begin
      clear_table();
      return res;
    end
    if (key == '0) begin
      return res;
    end
    for (int i = 0; i < NumSlots; i++) begin
      if (hit_at < 0 && tbl_used[i] && tbl_key[i] == key) begin
        hit_at = i;
      end
    end
    model_tick = model_tick + 1'b1;
    res.given = 1'b1;
    if (hit_at >= 0) begin
      tbl_stamp[hit_at] = model_tick;
      res.index = SlotOutW'(hit_at);
      res.hit   = 1'b1;
      return res;
    end
    for (int i = 0; i < NumSlots; i++) begin
      if (victim < 0 && !tbl_used[i]) begin
        victim = i;
      end
    end
    if (victim < 0) begin
      victim = 0;
      for (int i = 1; i < NumSlots; i++) begin
        if (tbl_stamp[i] < tbl_stamp[victim]) begin
          victim = i;
        end
      end
      res.evicted = 1'b1;
    end
    tbl_used[victim]  = 1'b1;
    tbl_stamp[victim] = model_tick;
    tbl_key[victim]   = key;
    res.index = SlotOutW'(victim);
    return res;
  endfunction

  task automatic push_req(mode_e mode, logic [KeyInW-1:0] key);
    lookup_queue.push_back('{mode: mode, key: key});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_slots.push_back(lru_lookup(in_mode, in_key));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (lookup_queue.size() != 0 &&
            ((sent_count >= 150 && sent_count < 300) || $urandom_range(99) >= 7)) begin
          next_req = lookup_queue.pop_front();
          in_valid <= 1'b1;
          in_mode  <= next_req.mode;
          in_key   <= next_req.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        rcvd_count <= rcvd_count + 1;
        if (expected_slots.size() == 0) begin
          $display("%0t: unexpected result transfer given=%0b index=%0d hit=%0b evicted=%0b",
                   $time, slot_given_o, slot_index_o, was_hit_o, evicted_used_o);
          error_count++;
        end else begin
          want = expected_slots.pop_front();
          if (slot_given_o !== want.given) begin
            $display("%0t: slot_given expected %0b actual %0b", $time, want.given, slot_given_o);
            error_count++;
          end
          if (slot_index_o !== want.index) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, want.index, slot_index_o);
            error_count++;
          end
          if (was_hit_o !== want.hit) begin
            $display("%0t: was_hit expected %0b actual %0b", $time, want.hit, was_hit_o);
            error_count++;
          end
          if (evicted_used_o !== want.evicted) begin
            $display("%0t: evicted_used expected %0b actual %0b",
                     $time, want.evicted, evicted_used_o);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_once && rcvd_count == 450) begin
        held_once <= 1'b1;
        hold_left <= 60;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (rcvd_count >= 150 && rcvd_count < 300) || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        timed_out <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned pick;
    clear_table();
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = $urandom() | 32'h1;
    end
    key_pool[0] = 32'h8000_0000;

    // Directed part: empty key, flush, extreme keys, fill, hits and LRU evictions.
    push_req(ModeFlush, 32'hFFFF_FFFF);
    push_req(ModeLookup, 32'h0000_0000);
    push_req(ModeFlush, 32'h0000_0000);
    push_req(ModeLookup, 32'hFFFF_FFFF);
    push_req(ModeLookup, 32'h0000_0001);
    push_req(ModeLookup, 32'h8000_0000);
    push_req(ModeLookup, 32'hFFFF_FFFF);
    push_req(ModeLookup, 32'h0000_0002);
    push_req(ModeLookup, 32'h0000_0000);
    push_req(ModeLookup, 32'h0000_0001);
    push_req(ModeLookup, 32'h0000_0002);
    push_req(ModeLookup, 32'h5555_AAAA);
    push_req(ModeLookup, 32'hFFFF_FFFF);
    push_req(ModeFlush, 32'h0000_0000);
    push_req(ModeLookup, 32'h0000_0001);
    push_req(ModeLookup, 32'h0000_0001);
    push_req(ModeLookup, 32'hAAAA_5555);

    // Random part: mostly a small key pool so hits and evictions dominate.
    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        push_req(ModeFlush, $urandom());
      end else if (pick < 7) begin
        push_req(ModeLookup, 32'h0000_0000);
      end else if (pick < 17) begin
        push_req(ModeLookup, $urandom());
      end else begin
        push_req(ModeLookup, key_pool[$urandom_range(PoolSize - 1)]);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((lookup_queue.size() != 0 || in_valid || expected_slots.size() != 0) && !timed_out) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);

    if (error_count == 0 && !timed_out) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
